/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the SOGI-FLL block, included by its top level.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// cond must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/sogi_pkg.sv */
// Package for the SOGI-FLL quadrature generator: widths, constants, codes,
// control struct and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package sogi_pkg;

  // Internal fixed point: signed Q(DW-FRAC_BITS).FRAC_BITS
  localparam int DW        = 32;
  localparam int FRAC_BITS = 16;

  // Port field widths
  localparam int IO_W   = 32;  // sample, alpha, beta, frequency_hz
  localparam int GAIN_W = 31;  // center frequency, k, fll gain
  localparam int STEP_W = 32;  // integration step, unsigned Q0.32
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;

  // Multiplier operand A holds signed data or an unsigned step/gain
  localparam int A_W   = ((DW > STEP_W) ? DW : STEP_W) + 1;
  localparam int P_W   = A_W + DW;
  localparam int ADD_W = (DW > GAIN_W + 4) ? DW : GAIN_W + 4;
  localparam int SUM_W = ADD_W + 1;
  localparam int EXT_W = (DW > IO_W) ? DW : IO_W;

  localparam logic signed [DW-1:0]   Q_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]   Q_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [IO_W-1:0] IO_MAX = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic signed [IO_W-1:0] IO_MIN = {1'b1, {(IO_W-1){1'b0}}};

  // 2*pi and 1/(2*pi) as unsigned Q.32
  localparam logic [63:0] TWO_PI_Q32     = 64'd26986075409;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  // 2*pi split into integer part and Q0.32 fraction so w0 needs one product
  localparam logic [63:0] TWO_PI_INT     = TWO_PI_Q32 >> 32;
  localparam logic [63:0] TWO_PI_FRAC    = TWO_PI_Q32 & 64'hFFFF_FFFF;

  localparam logic signed [DW-1:0]  ONE_Q     = DW'(64'd1 << FRAC_BITS);
  localparam logic signed [DW-1:0]  TWO_PI_FQ = DW'(TWO_PI_FRAC);
  localparam logic signed [DW-1:0]  INV_2PI_Q = DW'(INV_TWO_PI_Q32);
  localparam logic signed [P_W-1:0] HALF_Q32  = P_W'(64'h8000_0000);

  // Register reset values
  localparam logic [GAIN_W-1:0] CENTER_RESET = GAIN_W'(3276800);
  localparam logic [GAIN_W-1:0] K_RESET      = GAIN_W'(92682);
  localparam logic [GAIN_W-1:0] FLL_RESET    = '0;
  localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(429497);

  // w0 of the reset center frequency, rounded half up
  localparam logic [63:0] OMEGA_RESET_W =
    (64'(CENTER_RESET) * TWO_PI_Q32 + 64'h8000_0000) >> 32;
  localparam logic signed [DW-1:0] OMEGA_RESET = DW'(OMEGA_RESET_W);

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER,
    REG_K,
    REG_FLL,
    REG_STEP
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_OUT
  } state_t;

  // Passes through the shared multiplier, in issue order
  typedef enum logic [3:0] {
    OP_W0,
    OP_E1,
    OP_E2,
    OP_G,
    OP_ALPHA,
    OP_BETA,
    OP_P,
    OP_U,
    OP_WM,
    OP_W,
    OP_FREQ
  } op_t;

  typedef enum logic [1:0] {
    POST_ADD,   // scaled + addend
    POST_SUB,   // scaled - addend
    POST_RSUB   // addend - scaled
  } post_t;

  typedef struct packed {
    logic  sh32;   // shift by 32, else by FRAC_BITS
    logic  rnd;    // add one half LSB of Q.32 before the shift
    post_t post;
  } mul_ctl_t;

  function automatic logic signed [DW-1:0] sat_p(input logic signed [P_W-1:0] v);
    if (v > P_W'(Q_MAX)) return Q_MAX;
    if (v < P_W'(Q_MIN)) return Q_MIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_s(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(Q_MAX)) return Q_MAX;
    if (v < SUM_W'(Q_MIN)) return Q_MIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] enter_q(input logic signed [IO_W-1:0] v);
    logic signed [EXT_W-1:0] x;
    x = EXT_W'(v);
    if (x > EXT_W'(Q_MAX)) return Q_MAX;
    if (x < EXT_W'(Q_MIN)) return Q_MIN;
    return x[DW-1:0];
  endfunction

  function automatic logic signed [IO_W-1:0] emit_q(input logic signed [DW-1:0] v);
    logic signed [EXT_W-1:0] x;
    x = EXT_W'(v);
    if (x > EXT_W'(IO_MAX)) return IO_MAX;
    if (x < EXT_W'(IO_MIN)) return IO_MIN;
    return x[IO_W-1:0];
  endfunction

  // Gain register as a non-negative operand, held to the data range
  function automatic logic signed [A_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
    logic [A_W-1:0] x;
    x = A_W'(v);
    if (x > A_W'(Q_MAX)) x = A_W'(Q_MAX);
    return signed'(x);
  endfunction

endpackage

/* rtl/sogi_in_if.sv */
// Sample channel: valid/ready handshake with one signed Q16.16 sample a beat.
// Depends on sogi_pkg.
`timescale 1ns / 1ps

interface sogi_in_if import sogi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/sogi_out_if.sv */
// Result channel: valid/ready handshake carrying alpha, beta and frequency.
// Depends on sogi_pkg.
`timescale 1ns / 1ps

interface sogi_out_if import sogi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] alpha;
  logic signed [IO_W-1:0] beta;
  logic signed [IO_W-1:0] frequency_hz;

  modport source (output valid, output alpha, output beta, output frequency_hz,
                  input ready);
  modport sink   (input valid, input alpha, input beta, input frequency_hz,
                  output ready);
endinterface

/* rtl/sogi_fll_quadrature_generator.sv */
// SOGI-FLL quadrature generator, top level. Depends on sogi_pkg, sogi_in_if,
// sogi_out_if, sogi_mul_unit and assert_macros.svh.
`timescale 1ns / 1ps

// One grid sample in, one result (alpha, beta, frequency_hz) out, all signed
// Q16.16. Every product of the SOGI and the FLL runs through one shared
// multiplier that a small sequencer steps through eleven passes: w0 from the
// center frequency, e1, e2, g, alpha, beta, the FLL error product, u, the
// integrator update, omega and finally omega/(2*pi). Each pass is a product
// register step, then a shift/saturate/add step; an output state and an idle
// state follow the last pass. samples.ready drops at the accepting beat and
// rises again together with results.valid, when the output state hands the
// result to the output register, which lets a new sample be taken while the
// previous result still waits; only if that result is still unread at the
// end of the next sample does the sequencer hold. Configuration writes are
// registered and reach every later pass, also within a sample; a center
// frequency write does not touch the stored omega. There is no clearing pass
// after reset.

`include "assert_macros.svh"

module sogi_fll_quadrature_generator import sogi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  sogi_in_if.sink           samples,
  sogi_out_if.source        results
);

  // configuration
  logic [GAIN_W-1:0] center;
  logic [GAIN_W-1:0] k_gain;
  logic [GAIN_W-1:0] loop_gain;
  logic [STEP_W-1:0] step;

  // sequencer
  state_t state, state_next;
  op_t    op, op_next;

  // filter state and scratch
  logic signed [DW-1:0] sample_q;
  logic signed [DW-1:0] alpha_prev;
  logic signed [DW-1:0] beta_prev;
  logic signed [DW-1:0] freq_integrator;
  logic signed [DW-1:0] omega_prev;
  logic signed [DW-1:0] w0;
  logic signed [DW-1:0] e1;
  logic signed [DW-1:0] tmp;   // e2, then p, then u
  logic signed [DW-1:0] g;

  // output register
  logic                   out_valid;
  logic signed [IO_W-1:0] out_alpha;
  logic signed [IO_W-1:0] out_beta;
  logic signed [IO_W-1:0] out_freq;

  // multiplier hookup
  logic                    mul_load;
  logic signed [A_W-1:0]   mul_a;
  logic signed [DW-1:0]    mul_b;
  mul_ctl_t                mul_ctl;
  logic signed [ADD_W-1:0] mul_add;
  logic signed [DW-1:0]    mul_result;

  logic accept;
  logic out_free;
  logic signed [A_W-1:0] step_op;
  logic signed [A_W-1:0] center_op;

  assign accept    = samples.valid && samples.ready;
  assign out_free  = !out_valid || results.ready;
  assign step_op   = A_W'($signed({1'b0, step}));
  assign center_op = clamp_gain(center);

  //--------------------------------------------------------------------------
  // Configuration port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      center    <= CENTER_RESET;
      k_gain    <= K_RESET;
      loop_gain <= FLL_RESET;
      step      <= STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER: center    <= cfg_data[GAIN_W-1:0];
        REG_K:      k_gain    <= cfg_data[GAIN_W-1:0];
        REG_FLL:    loop_gain <= cfg_data[GAIN_W-1:0];
        REG_STEP:   step      <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer: next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MUL;
          op_next    = OP_W0;
        end
      end
      ST_MUL: state_next = ST_POST;
      ST_POST: begin
        if (op == OP_FREQ) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MUL;
          op_next    = op_t'(op + 4'd1);
        end
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_W0;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer: outputs
  //--------------------------------------------------------------------------
  always_comb begin
    samples.ready = (state == ST_IDLE);
    mul_load      = (state == ST_MUL);
  end

  // Operand selection per pass; operands stay put through the post cycle
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_ctl = '{sh32: 1'b0, rnd: 1'b0, post: POST_ADD};
    mul_add = '0;
    unique case (op)
      OP_W0: begin
        // w0 = int(2pi)*c + round(c * frac(2pi))
        mul_a   = center_op;
        mul_b   = TWO_PI_FQ;
        mul_ctl = '{sh32: 1'b1, rnd: 1'b1, post: POST_ADD};
        mul_add = ADD_W'(center_op) * ADD_W'(TWO_PI_INT);
      end
      OP_E1: begin
        mul_a   = A_W'(sample_q);
        mul_b   = ONE_Q;
        mul_ctl = '{sh32: 1'b0, rnd: 1'b0, post: POST_SUB};
        mul_add = ADD_W'(alpha_prev);
      end
      OP_E2: begin
        mul_a   = clamp_gain(k_gain);
        mul_b   = e1;
        mul_ctl = '{sh32: 1'b0, rnd: 1'b0, post: POST_SUB};
        mul_add = ADD_W'(beta_prev);
      end
      OP_G: begin
        mul_a   = step_op;
        mul_b   = omega_prev;
        mul_ctl = '{sh32: 1'b1, rnd: 1'b0, post: POST_ADD};
      end
      OP_ALPHA: begin
        mul_a   = A_W'(g);
        mul_b   = tmp;
        mul_add = ADD_W'(alpha_prev);
      end
      OP_BETA: begin
        // alpha_prev already holds this sample's alpha
        mul_a   = A_W'(g);
        mul_b   = alpha_prev;
        mul_add = ADD_W'(beta_prev);
      end
      OP_P: begin
        mul_a   = clamp_gain(loop_gain);
        mul_b   = e1;
      end
      OP_U: begin
        mul_a   = A_W'(tmp);
        mul_b   = beta_prev;
        mul_ctl = '{sh32: 1'b0, rnd: 1'b0, post: POST_RSUB};
      end
      OP_WM: begin
        mul_a   = step_op;
        mul_b   = tmp;
        mul_ctl = '{sh32: 1'b1, rnd: 1'b0, post: POST_ADD};
        mul_add = ADD_W'(freq_integrator);
      end
      OP_W: begin
        mul_a   = A_W'(freq_integrator);
        mul_b   = ONE_Q;
        mul_add = ADD_W'(w0);
      end
      OP_FREQ: begin
        mul_a   = A_W'(omega_prev);
        mul_b   = INV_2PI_Q;
        mul_ctl = '{sh32: 1'b1, rnd: 1'b0, post: POST_ADD};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  sogi_mul_unit u_mul (
    .clk    (clk),
    .load   (mul_load),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .ctl    (mul_ctl),
    .addend (mul_add),
    .result (mul_result)
  );

  //--------------------------------------------------------------------------
  // Datapath registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= enter_q(samples.sample);
    end
    if (state == ST_POST) begin
      unique case (op)
        OP_W0:    w0  <= mul_result;
        OP_E1:    e1  <= mul_result;
        OP_E2:    tmp <= mul_result;
        OP_G:     g   <= mul_result;
        OP_P:     tmp <= mul_result;
        OP_U:     tmp <= mul_result;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_prev      <= '0;
      beta_prev       <= '0;
      freq_integrator <= '0;
      omega_prev      <= OMEGA_RESET;
    end else if (state == ST_POST) begin
      unique case (op)
        OP_ALPHA: alpha_prev      <= mul_result;
        OP_BETA:  beta_prev       <= mul_result;
        OP_WM:    freq_integrator <= mul_result;
        OP_W:     omega_prev      <= mul_result;
        default:  ;
      endcase
    end
  end

  // Output register; in ST_OUT the unit still shows omega/(2*pi)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_alpha <= emit_q(alpha_prev);
      out_beta  <= emit_q(beta_prev);
      out_freq  <= emit_q(mul_result);
    end
  end

  assign results.valid        = out_valid;
  assign results.alpha        = out_alpha;
  assign results.beta         = out_beta;
  assign results.frequency_hz = out_freq;

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_starts, accept, state == ST_MUL && op == OP_W0, "sample beat did not start the sequence")
  `ASSERT_NEXT(a_mul_then_post, state == ST_MUL, state == ST_POST, "product not followed by post cycle")
  `ASSERT_HOLDS(a_out_after_last, state != ST_OUT || op == OP_FREQ, "output stage reached before last pass")
  `ASSERT_HOLDS(a_valid_from_out, !$rose(out_valid) || $past(state) == ST_OUT, "result beat raised outside output stage")

endmodule

/* rtl/sogi_mul_unit.sv */
// Shared multiply unit: registered signed product, then shift, saturate and
// a saturating add/subtract. Depends on sogi_pkg.
`timescale 1ns / 1ps

module sogi_mul_unit import sogi_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [A_W-1:0]   op_a,
  input  logic signed [DW-1:0]    op_b,
  input  mul_ctl_t                ctl,
  input  logic signed [ADD_W-1:0] addend,
  output logic signed [DW-1:0]    result
);

  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   rounded;
  logic signed [P_W-1:0]   shifted;
  logic signed [DW-1:0]    scaled;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= op_a * op_b;
    end
  end

  // arithmetic shift is a floor, matching truncation toward minus infinity
  always_comb begin
    rounded = ctl.rnd ? prod + HALF_Q32 : prod;
    shifted = ctl.sh32 ? (rounded >>> 32) : (rounded >>> FRAC_BITS);
    scaled  = sat_p(shifted);
    unique case (ctl.post)
      POST_ADD:  sum = SUM_W'(scaled) + SUM_W'(addend);
      POST_SUB:  sum = SUM_W'(scaled) - SUM_W'(addend);
      POST_RSUB: sum = SUM_W'(addend) - SUM_W'(scaled);
      default:   sum = SUM_W'(scaled);
    endcase
    result = sat_s(sum);
  end

endmodule

/* tb/sogi_fll_quadrature_generator_test.sv */
// Self-checking testbench for the SOGI-FLL quadrature generator.
// Depends on sogi_pkg, sogi_in_if, sogi_out_if and the sogi_fll_quadrature_generator RTL.
`timescale 1ns / 1ps

module sogi_fll_quadrature_generator_test import sogi_pkg::*; ();

  // Wide signed arithmetic for the predictor: products of a 33-bit and a
  // 64-bit operand never come close to 128 bits.
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [IO_W-1:0] alpha;
    logic signed [IO_W-1:0] beta;
    logic signed [IO_W-1:0] freq;
  } sogi_out_t;

  // Directed table: a row either writes a register (block idle) or sends
  // one sample. "pin" rows carry alpha/beta that are obvious by inspection.
  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    cfg_reg_t               idx;
    logic [31:0]            data;
    logic                   pin;
    logic signed [IO_W-1:0] want_alpha;
    logic signed [IO_W-1:0] want_beta;
  } drill_row_t;

  localparam int DRILL_N    = 26;
  localparam int PHASES     = 7;
  localparam int PHASE_LEN  = 200;
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
  localparam int SETTLE_GAP = 4;     // cycles after the last beat before a write
  localparam int TAIL_GAP   = 30;    // idle cycles after the final settle

  drill_row_t drill_rows [DRILL_N] = '{
    // out of reset, zero input: nothing moves
    '{ROW_SAMPLE, REG_CENTER, 32'h0000_0000, 1'b1, 32'sd0, 32'sd0},
    // zero step kills g, so alpha and beta stay at their zero state
    '{ROW_WRITE,  REG_STEP,   32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h7FFF_FFFF, 1'b1, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h8000_0000, 1'b1, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_STEP,   32'd429497,    1'b0, 32'sd0, 32'sd0},
    // top bit of a 31-bit register is dropped
    '{ROW_WRITE,  REG_FLL,    32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h0000_0001, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h0001_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'hFFFF_0000, 1'b0, 32'sd0, 32'sd0},
    // everything at the top: w0 saturates, outputs pin to the rails
    '{ROW_WRITE,  REG_CENTER, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_K,      32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_STEP,   32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h1234_5678, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    // everything at zero
    '{ROW_WRITE,  REG_CENTER, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_K,      32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_FLL,    32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_WRITE,  REG_STEP,   32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_CENTER, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  sogi_in_if  sample_ch ();
  sogi_out_if result_ch ();

  sogi_fll_quadrature_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // Predictor copy of the registers and of the loop state
  logic [GAIN_W-1:0] center_reg;
  logic [GAIN_W-1:0] k_reg;
  logic [GAIN_W-1:0] fll_reg;
  logic [STEP_W-1:0] step_reg;
  wide_t             w0_now;
  wide_t             st_alpha;
  wide_t             st_beta;
  wide_t             st_integ;
  wide_t             st_omega;

  sogi_out_t quad_due [$];   // outputs owed by the block, oldest first
  int        mismatches;

  // Shared between the stimulus and the receiver
  logic calm;       // no idling on either side
  logic hold_req;   // ask the receiver for its one long hold-off

  // Synthetic grid waveform for the random part
  real amp_v;
  real sig_hz;
  real ts_s;
  real ang;

  // Saturate to the signed data range
  function automatic wide_t clip(input wide_t v);
    if (v > wide_t'(Q_MAX)) return wide_t'(Q_MAX);
    if (v < wide_t'(Q_MIN)) return wide_t'(Q_MIN);
    return v;
  endfunction

  // Exact product, floor toward minus infinity, then saturate
  function automatic wide_t mul_q(input wide_t a, input wide_t b, input int sh);
    wide_t p;
    p = a * b;
    return clip(p >>> sh);
  endfunction

  // w0 = 2*pi*center, rounded half up, held to the positive max
  function automatic wide_t center_to_omega(input logic [GAIN_W-1:0] c);
    wide_t p;
    p = wide_t'(c) * wide_t'(TWO_PI_Q32);
    return clip((p + wide_t'(64'h8000_0000)) >>> 32);
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [31:0] d);
    case (idx)
      REG_CENTER: begin
        center_reg = d[GAIN_W-1:0];
        w0_now     = center_to_omega(center_reg);   // stored omega untouched
      end
      REG_K:    k_reg    = d[GAIN_W-1:0];
      REG_FLL:  fll_reg  = d[GAIN_W-1:0];
      REG_STEP: step_reg = d[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // One SOGI + FLL update; advances the state and returns the outputs
  function automatic sogi_out_t sogi_fll_update(input logic signed [IO_W-1:0] smp);
    wide_t x, e1, e2, g, a, b, p, u, wm, w;
    sogi_out_t r;
    x  = wide_t'(smp);
    e1 = clip(x - st_alpha);
    e2 = clip(mul_q(wide_t'(k_reg), e1, FRAC_BITS) - st_beta);
    g  = mul_q(wide_t'(step_reg), st_omega, 32);
    a  = clip(mul_q(g, e2, FRAC_BITS) + st_alpha);
    b  = clip(mul_q(g, a, FRAC_BITS) + st_beta);
    p  = mul_q(wide_t'(fll_reg), e1, FRAC_BITS);
    u  = clip(-mul_q(p, b, FRAC_BITS));
    wm = clip(mul_q(wide_t'(step_reg), u, 32) + st_integ);
    w  = clip(wm + w0_now);
    st_alpha = a;
    st_beta  = b;
    st_integ = wm;
    st_omega = w;
    r.alpha = a[IO_W-1:0];
    r.beta  = b[IO_W-1:0];
    r.freq  = IO_W'(mul_q(w, wide_t'(INV_TWO_PI_Q32), 32));
    return r;
  endfunction

  // Mostly a clean sine near the programmed frequency; some phase jumps,
  // small noise bursts and raw random words mixed in.
  function automatic logic [31:0] grid_sample();
    int unsigned pick;
    real v;
    pick = $urandom_range(99);
    if (pick < 80) begin
      ang = ang + 2.0 * 3.14159265358979 * sig_hz * ts_s;
      if ($urandom_range(199) == 0) ang = ang + 1.5707963;
      v = amp_v * $sin(ang) + amp_v * 0.02 * (real'($urandom_range(200)) / 100.0 - 1.0);
      return $rtoi(v * 65536.0);
    end else if (pick < 92) begin
      return 32'($urandom_range(2097152)) - 32'd1048576;
    end
    return $urandom();
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global time limit; a correct run ends well before it
  initial begin
    #5_000_000;
    $display("sogi_fll_quadrature_generator_test: done, errors");
    $finish;
  end

  // Register write: one beat of cfg_write, then a wait with cfg_write low
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    apply_reg(idx, d);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random sender gap, skipped in the calm stretch
  task automatic pause_sender();
    if (!calm && $urandom_range(99) < 7) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Offer one sample until it is taken, then log its expected outputs.
  // valid stays high so back-to-back beats need no second assignment.
  task automatic put_sample(input logic [31:0] s, input logic pin,
                            input logic signed [IO_W-1:0] pa,
                            input logic signed [IO_W-1:0] pb);
    sogi_out_t r;
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    r = sogi_fll_update(s);
    if (pin) begin
      r.alpha = pa;
      r.beta  = pb;
    end
    quad_due.push_back(r);
  endtask

  // Stop sending and wait until every owed result has been read
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (quad_due.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Program all four registers for one random phase
  task automatic program_phase(input int ph);
    logic [31:0] c, k, f, s;
    case (ph)
      2: begin                       // raw random words, top bits included
        c = $urandom();
        k = $urandom();
        f = $urandom();
        s = $urandom();
      end
      4: begin                       // all at the top
        c = 32'hFFFF_FFFF;
        k = 32'hFFFF_FFFF;
        f = 32'hFFFF_FFFF;
        s = 32'hFFFF_FFFF;
      end
      default: begin                 // a plausible grid setup
        c = ($urandom_range(45, 65) << 16) | $urandom_range(65535);
        k = $urandom_range(26214, 196608);
        f = (ph == 6) ? 32'd0 : $urandom_range(100 << 16);
        s = $urandom_range(100000, 1500000);
      end
    endcase
    write_reg(REG_CENTER, c);
    write_reg(REG_K, k);
    write_reg(REG_FLL, f);
    write_reg(REG_STEP, s);
    amp_v  = real'($urandom_range(1, 400));
    sig_hz = real'(c[GAIN_W-1:0]) / 65536.0 + real'($urandom_range(600)) / 100.0 - 3.0;
    ts_s   = real'(s) / 4294967296.0;
    ang    = 0.0;
  endtask

  // Main stimulus: reset, directed table, then random phases
  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    mismatches       = 0;

    center_reg = CENTER_RESET;
    k_reg      = K_RESET;
    fll_reg    = FLL_RESET;
    step_reg   = STEP_RESET;
    w0_now     = center_to_omega(center_reg);
    st_alpha   = '0;
    st_beta    = '0;
    st_integ   = '0;
    st_omega   = w0_now;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DRILL_N; i++) begin
      if (drill_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(drill_rows[i].idx, drill_rows[i].data);
      end else begin
        pause_sender();
        put_sample(drill_rows[i].data, drill_rows[i].pin,
                   drill_rows[i].want_alpha, drill_rows[i].want_beta);
      end
    end

    // Phase 1 runs with no idling at all; phase 3 carries the long
    // receiver hold-off so the output register fills and input stalls.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      program_phase(ph);
      calm = (ph == 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 3 && n == 40) hold_req = 1'b1;
        pause_sender();
        put_sample(grid_sample(), 1'b0, '0, '0);
      end
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_GAP) @(posedge clk);
    if (mismatches == 0) begin
      $display("sogi_fll_quadrature_generator_test: done, clean");
    end else begin
      $display("sogi_fll_quadrature_generator_test: done, errors");
    end
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    logic        held;
    hold_left       = 0;
    held            = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Result checker: every accepted beat against the oldest owed output
  always @(posedge clk) begin : check_results
    sogi_out_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (quad_due.size() == 0) begin
        $error("result beat with no sample outstanding");
        mismatches++;
      end else begin
        want = quad_due.pop_front();
        if (result_ch.alpha !== want.alpha) begin
          $error("alpha: expected %0d, got %0d", want.alpha, result_ch.alpha);
          mismatches++;
        end
        if (result_ch.beta !== want.beta) begin
          $error("beta: expected %0d, got %0d", want.beta, result_ch.beta);
          mismatches++;
        end
        if (result_ch.frequency_hz !== want.freq) begin
          $error("frequency_hz: expected %0d, got %0d", want.freq,
                 result_ch.frequency_hz);
          mismatches++;
        end
      end
    end
  end

endmodule
